[rtl/core/utx_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utx_pkg
// shared types and constants of the fifo fed 8n1 uart transmitter
// ----------------------------------------------------------------------------
package utx_pkg;

   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam int         DATA_BITS = 8;
   localparam int         BIT_IDX_W = $clog2(DATA_BITS);

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_START = 2'd1,
      PH_DATA  = 2'd2,
      PH_STOP  = 2'd3
   } tx_phase_type;

   // one stored entry: a byte, optionally preceded by a carriage return
   typedef struct packed {
      logic       cr_flag;
      logic [7:0] data;
   } fifo_entry_type;

   typedef struct packed {
      logic           push;
      logic           push_two;
      fifo_entry_type push_entry;
      logic           pop_byte;
      logic           pop_entry;
   } fifo_ctrl_type;

   typedef struct packed {
      logic       line_level;
      logic       write_accepted;
      logic       busy_res;
      logic [7:0] fifo_count;
   } rsp_payload_type;

endpackage
`default_nettype wire

[rtl/core/utx_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utx_req_if
// request channel: write byte or baud tick
// ----------------------------------------------------------------------------
interface utx_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] char_byte;

   modport source (output valid, output req_type, output char_byte, input ready);
   modport sink   (input valid, input req_type, input char_byte, output ready);
endinterface
`default_nettype wire

[rtl/core/utx_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utx_rsp_if
// response channel: line level and fifo status after each request
// ----------------------------------------------------------------------------
interface utx_rsp_if;
   logic       valid;
   logic       ready;
   logic       line_level;
   logic       write_accepted;
   logic       busy_res;
   logic [7:0] fifo_count;

   modport source (output valid, output line_level, output write_accepted,
                   output busy_res, output fifo_count, input ready);
   modport sink   (input valid, input line_level, input write_accepted,
                   input busy_res, input fifo_count, output ready);
endinterface
`default_nettype wire

[rtl/core/utx_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utx_fifo
// byte fifo: entry memory with registered read, pointers and byte count
// ----------------------------------------------------------------------------
module utx_fifo #(
   parameter int FIFO_DEPTH = 128
) (
   input  wire                                logic clock,
   input  wire                                logic reset,
   input  wire utx_pkg::fifo_ctrl_type        ctrl,
   output logic [$clog2(FIFO_DEPTH+1)-1:0]    count,
   output logic [$clog2(FIFO_DEPTH+1)-1:0]    count_next,
   output utx_pkg::fifo_entry_type            rd_entry
);
   import utx_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH+1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

   fifo_entry_type   mem_ff [FIFO_DEPTH];
   fifo_entry_type   rd_data_ff;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (ctrl.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         count_in  = count_ff + (ctrl.push_two ? CNT_W'(2) : CNT_W'(1));
      end
      if (ctrl.pop_entry) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (ctrl.pop_byte) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem_ff[wr_ptr_ff] <= ctrl.push_entry;
      end
      if (ctrl.pop_entry) begin
         rd_data_ff <= mem_ff[rd_ptr_ff];
      end
   end

   assign count      = count_ff;
   assign count_next = count_in;
   assign rd_entry   = rd_data_ff;
endmodule
`default_nettype wire

[rtl/core/utx_serial.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utx_serial
// request decode, cr/lf expansion, admission check and 8n1 bit sequencer
// ----------------------------------------------------------------------------
module utx_serial #(
   parameter int FIFO_DEPTH = 128
) (
   input  wire                              logic clock,
   input  wire                              logic reset,
   input  wire                              logic csr_wr_en,
   input  wire                              logic csr_wr_data,
   input  wire                              logic fire,
   input  wire                              logic req_type,
   input  wire                              logic [7:0] char_byte,
   input  wire logic [$clog2(FIFO_DEPTH+1)-1:0]  count,
   input  wire logic [$clog2(FIFO_DEPTH+1)-1:0]  count_next,
   input  wire utx_pkg::fifo_entry_type     rd_entry,
   output utx_pkg::fifo_ctrl_type           ctrl,
   output utx_pkg::rsp_payload_type         result
);
   import utx_pkg::*;

   localparam int CNT_W = $clog2(FIFO_DEPTH+1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(FIFO_DEPTH);
   localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(DATA_BITS - 1);

   tx_phase_type         phase_ff, phase_in;
   logic [BIT_IDX_W-1:0] bit_idx_ff, bit_idx_in;
   logic                 line_ff, line_in;
   logic                 sel_cr_ff, sel_cr_in;
   logic                 half_ff, half_in;
   logic                 crlf_ff;

   logic                 expand;
   logic [CNT_W-1:0]     room;
   logic                 fits;
   logic                 send_cr;
   logic [7:0]           tx_byte;
   logic [CNT_W+7:0]     count_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         crlf_ff <= 1'b1;
      end else if (csr_wr_en) begin
         crlf_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         bit_idx_ff <= '0;
         line_ff    <= 1'b1;
         sel_cr_ff  <= 1'b0;
         half_ff    <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         bit_idx_ff <= bit_idx_in;
         line_ff    <= line_in;
         sel_cr_ff  <= sel_cr_in;
         half_ff    <= half_in;
      end
   end

   assign expand  = crlf_ff && (char_byte == CH_LF);
   assign room    = DEPTH_C - count;
   assign fits    = expand ? (room >= CNT_W'(2)) : (room >= CNT_W'(1));
   assign send_cr = rd_entry.cr_flag && sel_cr_ff;
   assign tx_byte = send_cr ? CH_CR : rd_entry.data;

   always_comb begin
      phase_in   = phase_ff;
      bit_idx_in = bit_idx_ff;
      line_in    = line_ff;
      sel_cr_in  = sel_cr_ff;
      half_in    = half_ff;

      ctrl.push               = 1'b0;
      ctrl.push_two           = expand;
      ctrl.push_entry.cr_flag = expand;
      ctrl.push_entry.data    = char_byte;
      ctrl.pop_byte           = 1'b0;
      ctrl.pop_entry          = 1'b0;

      result.write_accepted = 1'b0;

      if (fire) begin
         if (req_type == REQ_WRITE) begin
            if (fits) begin
               ctrl.push             = 1'b1;
               result.write_accepted = 1'b1;
               if (phase_ff == PH_IDLE) begin
                  phase_in = PH_START;
               end
            end
         end else begin
            case (phase_ff)
               PH_START: begin
                  if (count == '0) begin
                     line_in  = 1'b1;
                     phase_in = PH_IDLE;
                  end else begin
                     line_in       = 1'b0;
                     ctrl.pop_byte = 1'b1;
                     bit_idx_in    = '0;
                     phase_in      = PH_DATA;
                     // second half of an expanded line feed stays in the read register
                     if (half_ff) begin
                        sel_cr_in = 1'b0;
                        half_in   = 1'b0;
                     end else begin
                        ctrl.pop_entry = 1'b1;
                        sel_cr_in      = 1'b1;
                     end
                  end
               end
               PH_DATA: begin
                  line_in    = tx_byte[bit_idx_ff];
                  half_in    = send_cr;
                  bit_idx_in = bit_idx_ff + BIT_IDX_W'(1);
                  if (bit_idx_ff == LAST_BIT) begin
                     phase_in = PH_STOP;
                  end
               end
               PH_STOP: begin
                  line_in  = 1'b1;
                  phase_in = (count == '0) ? PH_IDLE : PH_START;
               end
               default: begin
               end
            endcase
         end
      end

      count_wide        = {8'b0, count_next};
      result.line_level = line_in;
      result.busy_res   = (phase_in != PH_IDLE);
      result.fifo_count = count_wide[7:0];
   end
endmodule
`default_nettype wire

[rtl/core/utx_rsp_buf.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utx_rsp_buf
// two entry response buffer between the datapath and the response channel
// ----------------------------------------------------------------------------
module utx_rsp_buf (
   input  wire                      logic clock,
   input  wire                      logic reset,
   input  wire                      logic push,
   input  wire utx_pkg::rsp_payload_type push_data,
   output logic                     in_ready,
   output logic                     out_valid,
   input  wire                      logic out_ready,
   output utx_pkg::rsp_payload_type out_data
);
   import utx_pkg::*;

   rsp_payload_type slot0_ff, slot0_in;
   rsp_payload_type slot1_ff, slot1_in;
   logic            valid0_ff, valid0_in;
   logic            valid1_ff, valid1_in;
   logic            pop;

   assign pop = valid0_ff && out_ready;

   always_comb begin
      slot0_in  = slot0_ff;
      slot1_in  = slot1_ff;
      valid0_in = valid0_ff;
      valid1_in = valid1_ff;
      if (pop) begin
         slot0_in  = valid1_ff ? slot1_ff : push_data;
         valid0_in = valid1_ff || push;
         valid1_in = 1'b0;
      end else if (push) begin
         if (valid0_ff) begin
            slot1_in  = push_data;
            valid1_in = 1'b1;
         end else begin
            slot0_in  = push_data;
            valid0_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
         valid1_ff <= 1'b0;
      end else begin
         valid0_ff <= valid0_in;
         valid1_ff <= valid1_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign in_ready  = !valid1_ff;
   assign out_valid = valid0_ff;
   assign out_data  = slot0_ff;
endmodule
`default_nettype wire

[rtl/core/uart_tx_fifo_serializer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// uart_tx_fifo_serializer
// 8n1 uart transmitter with byte fifo, cr/lf expansion and reject on full
// ----------------------------------------------------------------------------
// response: each result is registered in the response buffer
// throughput: 1 request per cycle, ready drops only with two responses pending
// a fifo pop reads the entry memory into a register on the start bit tick
// reset: pointers, byte count and sequencer cleared, line high, cr/lf mode on
// reset: fifo memory contents are not cleared
// ----------------------------------------------------------------------------
module uart_tx_fifo_serializer #(
   parameter int FIFO_DEPTH = 128
) (
   input  wire  logic  clock,
   input  wire  logic  reset,
   utx_req_if.sink     req_bus,
   utx_rsp_if.source   rsp_bus,
   input  wire  logic  csr_wr_en,
   input  wire  logic  csr_wr_data
);
   import utx_pkg::*;

   localparam int CNT_W = $clog2(FIFO_DEPTH+1);

   fifo_ctrl_type   ctrl;
   fifo_entry_type  rd_entry;
   rsp_payload_type result;
   rsp_payload_type out_data;
   logic [CNT_W-1:0] count;
   logic [CNT_W-1:0] count_next;
   logic            in_ready;
   logic            fire;

   assign req_bus.ready = in_ready;
   assign fire          = req_bus.valid && in_ready;

   utx_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .count      (count),
      .count_next (count_next),
      .rd_entry   (rd_entry)
   );

   utx_serial #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_serial (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (fire),
      .req_type    (req_bus.req_type),
      .char_byte   (req_bus.char_byte),
      .count       (count),
      .count_next  (count_next),
      .rd_entry    (rd_entry),
      .ctrl        (ctrl),
      .result      (result)
   );

   utx_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .push_data (result),
      .in_ready  (in_ready),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (out_data)
   );

   assign rsp_bus.line_level     = out_data.line_level;
   assign rsp_bus.write_accepted = out_data.write_accepted;
   assign rsp_bus.busy_res       = out_data.busy_res;
   assign rsp_bus.fifo_count     = out_data.fifo_count;
endmodule
`default_nettype wire

[sim/tb_uart_tx_fifo_serializer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_tx_fifo_serializer
// self-checking bench for the fifo fed 8n1 uart transmitter: a short table of
// hand-picked requests, then random write / baud tick mixes under both cr/lf
// modes; responses checked against pinned rows or a cycle-free line predictor
// ----------------------------------------------------------------------------
module tb_uart_tx_fifo_serializer;
   import utx_pkg::*;

   localparam int FIFO_DEPTH  = 128;
   localparam int STALL_LIMIT = 2000;
   localparam int SEG_COUNT   = 9;
   localparam int SEG_ITEMS   = 150;
   localparam int DIR_COUNT   = 22;

   typedef struct packed {
      logic            kind;
      logic [7:0]      ch;
      logic            pinned;
      rsp_payload_type rsp;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   utx_req_if req_if ();
   utx_rsp_if rsp_if ();

   uart_tx_fifo_serializer #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state
   logic [7:0]      tx_fifo_mem [FIFO_DEPTH];
   logic [6:0]      wr_ptr;
   logic [6:0]      rd_ptr;
   logic            full_flag;
   tx_phase_type    phase;
   logic [7:0]      shift_reg;
   logic [3:0]      bit_cnt;
   logic            line_q;
   logic            crlf_mode;

   rsp_payload_type line_expected [$];
   int              req_seen;
   int              rsp_seen;
   int              quiet_cycles;
   int              err_count;
   bit              pin_on;
   rsp_payload_type pin_rsp;
   bit              calm;
   bit              stall_on;
   int              hold_cnt;

   int              n_writes;
   int              n_ticks;
   int              n_rejects;
   int              n_expands;
   int              n_full;
   int              n_framed;

   stim_row_type dir_rows [DIR_COUNT] = '{
      // tick while idle, then a plain byte and an expanded line feed
      {REQ_TICK,  8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 8'd0},
      {REQ_WRITE, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 8'd1},
      {REQ_WRITE, CH_LF, 1'b1, 1'b1, 1'b1, 1'b1, 8'd3},
      // start bit pops 0xff, then eight high data bits
      {REQ_TICK,  8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 8'd2},
      {REQ_TICK,  8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 8'd2},
      {REQ_TICK,  8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, 8'd2},
      {REQ_TICK,  8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 8'd2},
      {REQ_TICK,  8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, 8'd2},
      {REQ_TICK,  8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 8'd2},
      {REQ_TICK,  8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, 8'd2},
      {REQ_TICK,  8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 8'd2},
      {REQ_TICK,  8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, 8'd2},
      // stop bit with bytes still queued, then the inserted carriage return
      {REQ_TICK,  8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 8'd2},
      {REQ_TICK,  8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 8'd1},
      // writes while busy, then baud ticks
      {REQ_WRITE, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 8'd2},
      {REQ_WRITE, 8'h80, 1'b0, 11'd0},
      {REQ_TICK,  8'h00, 1'b0, 11'd0},
      {REQ_TICK,  8'h00, 1'b0, 11'd0},
      {REQ_TICK,  8'h00, 1'b0, 11'd0},
      {REQ_TICK,  8'h00, 1'b0, 11'd0},
      {REQ_TICK,  8'h00, 1'b0, 11'd0},
      {REQ_TICK,  8'h00, 1'b0, 11'd0}
   };

   always #6 clock = ~clock;

   function automatic logic [7:0] fifo_level();
      logic [6:0] diff;
      diff = wr_ptr - rd_ptr;
      return full_flag ? 8'(FIFO_DEPTH) : {1'b0, diff};
   endfunction

   function automatic void fifo_push(logic [7:0] b);
      tx_fifo_mem[wr_ptr] = b;
      wr_ptr = wr_ptr + 7'd1;
      full_flag = (wr_ptr == rd_ptr);
   endfunction

   function automatic rsp_payload_type tx_line_predict(logic kind, logic [7:0] ch);
      rsp_payload_type r;
      logic            expand;
      int              room;
      r.write_accepted = 1'b0;
      if (kind == REQ_WRITE) begin
         n_writes++;
         expand = crlf_mode && (ch == CH_LF);
         room = FIFO_DEPTH - int'(fifo_level());
         if (room >= (expand ? 2 : 1)) begin
            if (expand) begin
               fifo_push(CH_CR);
               n_expands++;
            end
            fifo_push(ch);
            r.write_accepted = 1'b1;
            if (phase == PH_IDLE) phase = PH_START;
         end else begin
            n_rejects++;
         end
      end else begin
         n_ticks++;
         case (phase)
            PH_START: begin
               if (fifo_level() == 8'd0) begin
                  line_q = 1'b1;
                  phase = PH_IDLE;
               end else begin
                  line_q = 1'b0;
                  shift_reg = tx_fifo_mem[rd_ptr];
                  rd_ptr = rd_ptr + 7'd1;
                  full_flag = 1'b0;
                  bit_cnt = 4'd0;
                  phase = PH_DATA;
                  n_framed++;
               end
            end
            PH_DATA: begin
               line_q = shift_reg[bit_cnt[2:0]];
               bit_cnt = bit_cnt + 4'd1;
               if (bit_cnt >= 4'(DATA_BITS)) phase = PH_STOP;
            end
            PH_STOP: begin
               line_q = 1'b1;
               phase = (fifo_level() == 8'd0) ? PH_IDLE : PH_START;
            end
            default: ;
         endcase
      end
      r.line_level = line_q;
      r.busy_res   = (phase != PH_IDLE);
      r.fifo_count = fifo_level();
      if (r.fifo_count == 8'(FIFO_DEPTH)) n_full++;
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      err_count++;
      if (err_count <= 40)
         $display("response %0d: %s got 0x%0h expected 0x%0h", rsp_seen, what, got, want);
   endtask

   // request monitor, predictor and response checker
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (reset) begin
         wr_ptr    = '0;
         rd_ptr    = '0;
         full_flag = 1'b0;
         phase     = PH_IDLE;
         shift_reg = '0;
         bit_cnt   = '0;
         line_q    = 1'b1;
         crlf_mode = 1'b1;
      end else begin
         if (csr_wr_en) crlf_mode = csr_wr_data;
         if (req_if.valid && req_if.ready) begin
            want = tx_line_predict(req_if.req_type, req_if.char_byte);
            if (pin_on) want = pin_rsp;
            line_expected.push_back(want);
            req_seen++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = {rsp_if.line_level, rsp_if.write_accepted, rsp_if.busy_res,
                   rsp_if.fifo_count};
            if (line_expected.size() == 0) begin
               report_mismatch("unexpected response", int'(got), 0);
            end else begin
               want = line_expected.pop_front();
               if (got.line_level !== want.line_level)
                  report_mismatch("line_level", got.line_level, want.line_level);
               if (got.write_accepted !== want.write_accepted)
                  report_mismatch("write_accepted", got.write_accepted, want.write_accepted);
               if (got.busy_res !== want.busy_res)
                  report_mismatch("busy_res", got.busy_res, want.busy_res);
               if (got.fifo_count !== want.fifo_count)
                  report_mismatch("fifo_count", got.fifo_count, want.fifo_count);
            end
            rsp_seen++;
         end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
   end

   // response side back-pressure
   always @(negedge clock) begin
      if (hold_cnt != 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_if.ready <= 1'b0;
      end else if (stall_on && $urandom_range(0, 99) < 25) begin
         hold_cnt <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                  : $urandom_range(0, 2);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   initial begin
      do @(negedge clock); while (quiet_cycles < STALL_LIMIT);
      $display("timeout: no request or response moved for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 11);
      if (r < 2) return CH_LF;
      if (r == 2) return CH_CR;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_request(input logic kind, input logic [7:0] ch, input int gap,
                               input bit pinned, input rsp_payload_type want);
      int target;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      target  = req_seen + 1;
      pin_on  = pinned;
      pin_rsp = want;
      req_if.valid     <= 1'b1;
      req_if.req_type  <= kind;
      req_if.char_byte <= ch;
      do @(negedge clock); while (req_seen != target);
   endtask

   // quiesce the request channel, then write the cr/lf mode
   task automatic write_crlf(input logic mode);
      req_if.valid <= 1'b0;
      while (line_expected.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      int write_pct [SEG_COUNT] = '{90, 15, 50, 95, 10, 60, 85, 20, 40};
      logic kind;
      clock            = 1'b0;
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = 1'b0;
      req_if.valid     = 1'b0;
      req_if.req_type  = REQ_WRITE;
      req_if.char_byte = 8'h00;
      rsp_if.ready     = 1'b0;
      hold_cnt         = 0;
      calm             = 1'b0;
      stall_on         = 1'b1;
      pin_on           = 1'b0;
      pin_rsp          = '0;
      req_seen         = 0;
      rsp_seen         = 0;
      quiet_cycles     = 0;
      err_count        = 0;
      n_writes = 0; n_ticks = 0; n_rejects = 0; n_expands = 0; n_full = 0; n_framed = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i])
         send_request(dir_rows[i].kind, dir_rows[i].ch, pick_gap(), dir_rows[i].pinned,
                      dir_rows[i].rsp);

      for (int seg = 0; seg < SEG_COUNT; seg++) begin
         write_crlf((seg % 3 == 1) ? 1'b0 : 1'b1);
         calm     = (seg % 4 == 2);
         stall_on = !calm;
         for (int n = 0; n < SEG_ITEMS; n++) begin
            kind = ($urandom_range(0, 99) < write_pct[seg]) ? REQ_WRITE : REQ_TICK;
            send_request(kind, pick_byte(), pick_gap(), 1'b0, '0);
         end
      end
      write_crlf(1'b1);

      req_if.valid <= 1'b0;
      while (line_expected.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (line_expected.size() != 0)
         report_mismatch("responses still missing", 0, line_expected.size());

      $display("covered %0d requests: %0d writes (%0d rejected for lack of room, %0d cr/lf inserts), %0d baud ticks",
               req_seen, n_writes, n_rejects, n_expands, n_ticks);
      $display("fifo seen full after %0d requests, %0d bytes framed, %0d mismatches",
               n_full, n_framed, err_count);
      if (err_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

[files.f]
rtl/core/utx_pkg.sv
rtl/core/utx_req_if.sv
rtl/core/utx_rsp_if.sv
rtl/core/utx_fifo.sv
rtl/core/utx_serial.sv
rtl/core/utx_rsp_buf.sv
rtl/core/uart_tx_fifo_serializer.sv
sim/tb_uart_tx_fifo_serializer.sv
